// ===== rtl/ibce_pkg.sv =====
package ibce_pkg;

    // One bus event or flash word as it arrives
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  rx_byte;
        logic [15:0] flash_word;
    } t_in_item;

    // One result as it leaves
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] flash_addr;
        logic [15:0] write_word;
        logic        last;
    } t_out_item;

    // Bus event codes on the input mode field
    typedef enum logic [2:0] {
        MODE_WR_ADDR = 3'd0,
        MODE_WR_DATA = 3'd1,
        MODE_RD_ADDR = 3'd2,
        MODE_RD_DATA = 3'd3,
        MODE_FWORD   = 3'd4
    } t_mode;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_WDATA,
        OP_RADDR,
        OP_RDATA,
        OP_FWORD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  rx_byte;
        logic [15:0] flash_word;
    } t_cmd;

    // Result kinds
    localparam logic [2:0] KIND_TX        = 3'd0;
    localparam logic [2:0] KIND_BLOCK_REQ = 3'd1;
    localparam logic [2:0] KIND_ERASE     = 3'd2;
    localparam logic [2:0] KIND_WRITE     = 3'd3;
    localparam logic [2:0] KIND_RESET     = 3'd4;
    localparam logic [2:0] KIND_SESSION   = 3'd5;

    // Bootloader command codes
    localparam logic [7:0] CMD_SET_ADDR   = 8'h01;
    localparam logic [7:0] CMD_LOAD_BUF   = 8'h02;
    localparam logic [7:0] CMD_BLOCK_READ = 8'h03;
    localparam logic [7:0] CMD_ERASE      = 8'h04;
    localparam logic [7:0] CMD_PROGRAM    = 8'h05;
    localparam logic [7:0] CMD_RESET      = 8'h06;
    localparam logic [7:0] TX_RESET_ACK   = 8'hA0;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = 2;

    // Back-end sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_BUF_TX,
        S_PROG_RD,
        S_PROG,
        S_TX0,
        S_RST
    } t_state;

endpackage

// ===== rtl/ibce_front.sv =====
module ibce_front
    import ibce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_cmd     o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_op  op;

    // Classify the event; unused mode codes are dropped here
    always_comb begin
        unique case (i_in_item.mode)
            MODE_WR_ADDR: op = OP_START;
            MODE_WR_DATA: op = OP_WDATA;
            MODE_RD_ADDR: op = OP_RADDR;
            MODE_RD_DATA: op = OP_RDATA;
            MODE_FWORD:   op = OP_FWORD;
            default:      op = OP_NONE;
        endcase
    end

    assign o_in_ready = !r_valid || i_ready;

    // Holding stage in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && (op != OP_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd.op         <= op;
            r_cmd.rx_byte    <= i_in_item.rx_byte;
            r_cmd.flash_word <= i_in_item.flash_word;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ===== rtl/ibce_queue.sv =====
module ibce_queue
    import ibce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd            r_entries [QUEUE_DEPTH];
    logic [QA_W:0]   r_wr_ptr;
    logic [QA_W:0]   r_rd_ptr;
    logic            full;
    logic            empty;
    logic            push;
    logic            pop;

    assign empty = (r_wr_ptr == r_rd_ptr);
    assign full  = (r_wr_ptr[QA_W] != r_rd_ptr[QA_W]) &&
                   (r_wr_ptr[QA_W-1:0] == r_rd_ptr[QA_W-1:0]);
    assign push  = i_valid && !full;
    assign pop   = !empty && i_ready;

    assign o_ready = !full;
    assign o_valid = !empty;
    assign o_cmd   = r_entries[r_rd_ptr[QA_W-1:0]];

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_wr_ptr[QA_W-1:0]] <= i_cmd;
        end
    end

endmodule

// ===== rtl/ibce_back.sv =====
module ibce_back
    import ibce_pkg::*;
#(
    parameter int BLOCK_BYTES = 64,
    parameter int BLOCK_WORDS = 32,
    parameter int ERASE_WORDS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int MEM_WORDS = (BLOCK_BYTES + 1) / 2;
    localparam int MEM_BYTES = 2 * MEM_WORDS;
    localparam int MA_W      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CNT_W     = $clog2(BLOCK_WORDS + 1);
    localparam int WI_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    // Architectural state
    t_state               r_state, n_state;
    logic [7:0]           r_byte_index, n_byte_index;
    logic [7:0]           r_cmd, n_cmd;
    logic [15:0]          r_ptr, n_ptr;
    logic                 r_fetch_pending, n_fetch_pending;
    logic [CNT_W-1:0]     r_fetch_count, n_fetch_count;
    logic [MEM_BYTES-1:0] r_valid_bits;

    // Sequencer working registers
    logic [7:0]           r_rd_byte, n_rd_byte;
    logic [WI_W-1:0]      r_word_i, n_word_i;
    logic                 r_lane_lo;

    // Page buffer, 16-bit words, even byte in the high lane
    logic [15:0]          r_mem [MEM_WORDS];
    logic [15:0]          r_rd_data;
    logic [1:0]           r_rd_ok;

    // Output register
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic                 out_free;
    logic                 pop;
    logic                 emit;
    t_out_item            emit_item;
    logic                 rd_en;
    logic [6:0]           rd_word;
    logic [MA_W-1:0]      rd_addr;
    logic                 rd_in_range;
    logic                 wr_en;
    logic [MA_W-1:0]      wr_addr;
    logic [1:0]           wr_be;
    logic [15:0]          wr_data;
    logic                 soft_clr;
    logic [7:0]           eff_idx;
    logic [7:0]           load_pos;
    logic [7:0]           fc8;
    logic [7:0]           hi_pos;
    logic                 hi_ok;
    logic                 lo_ok;
    logic                 fetch_end;
    logic                 prog_last;
    logic [7:0]           buf_hi;
    logic [7:0]           buf_lo;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign pop         = i_cmd_valid && o_cmd_ready;

    assign eff_idx   = (i_cmd.op == OP_RADDR) ? 8'd0 : r_byte_index;
    assign load_pos  = r_byte_index - 8'd1;
    assign fc8       = 8'(r_fetch_count);
    assign hi_pos    = {fc8[6:0], 1'b0};
    assign hi_ok     = {1'b0, hi_pos} < 9'(BLOCK_BYTES);
    assign lo_ok     = {1'b0, hi_pos} + 9'd1 < 9'(BLOCK_BYTES);
    assign fetch_end = (r_fetch_count == CNT_W'(BLOCK_WORDS - 1));
    assign prog_last = (r_word_i == WI_W'(BLOCK_WORDS - 1));
    assign buf_hi    = r_rd_ok[1] ? r_rd_data[15:8] : 8'd0;
    assign buf_lo    = r_rd_ok[0] ? r_rd_data[7:0] : 8'd0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.op)
                        OP_RADDR, OP_RDATA: begin
                            unique case (r_cmd)
                                CMD_BLOCK_READ: n_state = (eff_idx == 8'd0) ? S_IDLE : S_RD;
                                CMD_ERASE:      n_state = (eff_idx == 8'd0) ? S_TX0 : S_IDLE;
                                CMD_PROGRAM:    n_state = (eff_idx == 8'd0) ? S_PROG_RD : S_IDLE;
                                CMD_RESET:      n_state = S_RST;
                                default:        n_state = S_IDLE;
                            endcase
                        end
                        OP_FWORD: begin
                            if (r_fetch_pending && fetch_end) begin
                                n_state = S_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:      n_state = S_BUF_TX;
            S_BUF_TX:  n_state = out_free ? S_IDLE : S_BUF_TX;
            S_PROG_RD: n_state = S_PROG;
            S_PROG:    n_state = (out_free && prog_last) ? S_TX0 : S_PROG;
            S_TX0:     n_state = out_free ? S_IDLE : S_TX0;
            S_RST:     n_state = out_free ? S_IDLE : S_RST;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, results and buffer accesses
    always_comb begin
        n_byte_index    = r_byte_index;
        n_cmd           = r_cmd;
        n_ptr           = r_ptr;
        n_fetch_pending = r_fetch_pending;
        n_fetch_count   = r_fetch_count;
        n_rd_byte       = r_rd_byte;
        n_word_i        = r_word_i;
        emit            = 1'b0;
        emit_item       = '0;
        rd_en           = 1'b0;
        rd_word         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_be           = '0;
        wr_data         = '0;
        soft_clr        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.op)
                        OP_START: begin
                            n_byte_index    = '0;
                            n_cmd           = '0;
                            n_fetch_pending = 1'b0;
                            n_fetch_count   = '0;
                            emit            = 1'b1;
                            emit_item.kind  = KIND_SESSION;
                            emit_item.last  = 1'b1;
                        end
                        OP_WDATA: begin
                            if (r_byte_index == 8'd0) begin
                                n_cmd = i_cmd.rx_byte;
                            end else if (r_cmd == CMD_SET_ADDR) begin
                                if (r_byte_index == 8'd1) begin
                                    n_ptr[7:0] = i_cmd.rx_byte;
                                end else if (r_byte_index == 8'd2) begin
                                    n_ptr[15:8] = i_cmd.rx_byte;
                                end
                            end else if (r_cmd == CMD_LOAD_BUF) begin
                                if ({1'b0, r_byte_index} <= 9'(BLOCK_BYTES)) begin
                                    wr_en   = 1'b1;
                                    wr_addr = MA_W'(load_pos[7:1]);
                                    wr_be   = load_pos[0] ? 2'b01 : 2'b10;
                                    wr_data = {i_cmd.rx_byte, i_cmd.rx_byte};
                                end
                            end
                            n_byte_index = r_byte_index + 8'd1;
                        end
                        OP_RADDR, OP_RDATA: begin
                            n_byte_index = eff_idx + 8'd1;
                            unique case (r_cmd)
                                CMD_SET_ADDR: begin
                                    emit              = 1'b1;
                                    emit_item.kind    = KIND_TX;
                                    emit_item.tx_byte = (eff_idx == 8'd0) ? r_ptr[7:0]
                                                                          : r_ptr[15:8];
                                    emit_item.last    = 1'b1;
                                end
                                CMD_BLOCK_READ: begin
                                    if (eff_idx == 8'd0) begin
                                        emit                 = 1'b1;
                                        emit_item.kind       = KIND_BLOCK_REQ;
                                        emit_item.flash_addr = r_ptr;
                                        emit_item.last       = 1'b1;
                                        n_fetch_pending      = 1'b1;
                                        n_fetch_count        = '0;
                                    end else begin
                                        n_rd_byte = eff_idx;
                                    end
                                end
                                CMD_ERASE: begin
                                    emit = 1'b1;
                                    if (eff_idx == 8'd0) begin
                                        emit_item.kind       = KIND_ERASE;
                                        emit_item.flash_addr = r_ptr;
                                        n_ptr                = r_ptr + 16'(ERASE_WORDS);
                                    end else begin
                                        emit_item.kind = KIND_TX;
                                        emit_item.last = 1'b1;
                                    end
                                end
                                CMD_PROGRAM: begin
                                    if (eff_idx == 8'd0) begin
                                        n_word_i = '0;
                                    end else begin
                                        emit           = 1'b1;
                                        emit_item.kind = KIND_TX;
                                        emit_item.last = 1'b1;
                                    end
                                end
                                CMD_RESET: begin
                                    emit              = 1'b1;
                                    emit_item.kind    = KIND_TX;
                                    emit_item.tx_byte = TX_RESET_ACK;
                                end
                                default: begin
                                    emit           = 1'b1;
                                    emit_item.kind = KIND_TX;
                                    emit_item.last = 1'b1;
                                end
                            endcase
                        end
                        OP_FWORD: begin
                            if (r_fetch_pending) begin
                                wr_en   = hi_ok || lo_ok;
                                wr_addr = MA_W'(r_fetch_count);
                                wr_be   = {hi_ok, lo_ok};
                                wr_data = i_cmd.flash_word;
                                n_ptr   = r_ptr + 16'd1;
                                if (fetch_end) begin
                                    n_fetch_pending = 1'b0;
                                    n_fetch_count   = '0;
                                    n_rd_byte       = 8'd0;
                                end else begin
                                    n_fetch_count = r_fetch_count + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                rd_word = r_rd_byte[7:1];
            end
            S_BUF_TX: begin
                if (out_free) begin
                    emit              = 1'b1;
                    emit_item.kind    = KIND_TX;
                    emit_item.tx_byte = r_lane_lo ? buf_lo : buf_hi;
                    emit_item.last    = 1'b1;
                end
            end
            S_PROG_RD: begin
                rd_en   = 1'b1;
                rd_word = '0;
            end
            S_PROG: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_item.kind       = KIND_WRITE;
                    emit_item.flash_addr = r_ptr + 16'(r_word_i);
                    emit_item.write_word = {buf_hi, buf_lo};
                    if (prog_last) begin
                        n_ptr = r_ptr + 16'(BLOCK_WORDS);
                    end else begin
                        n_word_i = r_word_i + 1'b1;
                        rd_en    = 1'b1;
                        rd_word  = 7'(r_word_i) + 7'd1;
                    end
                end
            end
            S_TX0: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_item.kind = KIND_TX;
                    emit_item.last = 1'b1;
                end
            end
            S_RST: begin
                if (out_free) begin
                    emit            = 1'b1;
                    emit_item.kind  = KIND_RESET;
                    emit_item.last  = 1'b1;
                    soft_clr        = 1'b1;
                    n_byte_index    = '0;
                    n_cmd           = '0;
                    n_ptr           = '0;
                    n_fetch_pending = 1'b0;
                    n_fetch_count   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_addr     = MA_W'(rd_word);
    assign rd_in_range = 8'(rd_word) < 8'(MEM_WORDS);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_byte_index    <= '0;
            r_cmd           <= '0;
            r_ptr           <= '0;
            r_fetch_pending <= 1'b0;
            r_fetch_count   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_byte_index    <= n_byte_index;
            r_cmd           <= n_cmd;
            r_ptr           <= n_ptr;
            r_fetch_pending <= n_fetch_pending;
            r_fetch_count   <= n_fetch_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-byte written flags; an unwritten byte reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || soft_clr) begin
            r_valid_bits <= '0;
        end else if (wr_en) begin
            if (wr_be[1]) begin
                r_valid_bits[{wr_addr, 1'b0}] <= 1'b1;
            end
            if (wr_be[0]) begin
                r_valid_bits[{wr_addr, 1'b1}] <= 1'b1;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        r_rd_byte <= n_rd_byte;
        r_word_i  <= n_word_i;
        if (r_state == S_RD) begin
            r_lane_lo <= r_rd_byte[0];
        end
        if (emit) begin
            r_out_item <= emit_item;
        end
    end

    // Page buffer memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (wr_be[1]) begin
                r_mem[wr_addr][15:8] <= wr_data[15:8];
            end
            if (wr_be[0]) begin
                r_mem[wr_addr][7:0] <= wr_data[7:0];
            end
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= {rd_in_range && r_valid_bits[{rd_addr, 1'b0}],
                          rd_in_range && r_valid_bits[{rd_addr, 1'b1}]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A result is only produced into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result produced while output slot busy");

    // No fetch in progress means the word count is at rest
    a_fetch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fetch_pending |-> (r_fetch_count == '0))
        else $error("fetch count moved without a pending fetch");

    // A buffer read is always followed by its transmit step
    a_rd_then_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_BUF_TX))
        else $error("buffer read not followed by transmit");

    // The reset result leaves the engine in its reset state
    a_soft_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        soft_clr |=> (r_cmd == '0) && (r_ptr == '0) && (r_valid_bits == '0))
        else $error("command reset did not clear state");

endmodule

// ===== rtl/i2c_boot_command_engine_core.sv =====
// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// output  | out       | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// Flow: an event passes a holding stage and a 4-deep queue, then the back-end
// sequencer takes one event per cycle while idle with its output slot free. Block-read
// bytes and the end-of-fetch byte pass S_RD and S_BUF_TX (one buffer read port,
// registered). Erase and reset add a result from S_TX0 or S_RST; a program emits
// one write-word result per cycle from the read port while the output is free.
// Reset: synchronous, active low; page buffer contents read as zero until
// written, via per-byte flags cleared at once, so there is no clearing pass.
// Stalls: output back-pressure holds the sequencer; the queue and the holding
// stage keep accepting until all five places are taken.
module i2c_boot_command_engine_core
    import ibce_pkg::*;
#(
    parameter int BLOCK_BYTES = 64,
    parameter int BLOCK_WORDS = 32,
    parameter int ERASE_WORDS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_ready;
    t_cmd queue_cmd;

    // Accept and classify bus events
    ibce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_valid    (front_valid),
        .i_ready    (front_ready),
        .o_cmd      (front_cmd)
    );

    // Decoupling queue
    ibce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_cmd   (queue_cmd)
    );

    // Command execution and result generation
    ibce_back #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_WORDS (BLOCK_WORDS),
        .ERASE_WORDS (ERASE_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
